>>> rtl/running_median_tracker_macros.svh
// Assertion macros shared by the running median tracker RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef RUNNING_MEDIAN_TRACKER_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, quiet while the synchronous reset is held.
`define RMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define RMT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RMT_ASSERT(lbl, prop, msg)
`define RMT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/rmt_pkg.sv
// Package for the running median tracker: default sizes and the cell control type.
// Depends on nothing; used by the interfaces, the cell and the top level.
package rmt_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SUM_W           = 64;

    // Broadcast to every cell in the chain for one insertion.
    typedef struct packed {
        logic en;          // an insertion happens this cycle
        logic shift_left;  // the median rank moves up: lower part slides left
    } t_cell_ctl;

endpackage

>>> rtl/rmt_if.sv
// Valid/ready stream interfaces for the input samples and the median results.
// Depends on rmt_pkg for the default widths.
interface rmt_in_if
    import rmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] new_value;

    modport source (output valid, output new_value, input ready);
    modport sink   (input valid, input new_value, output ready);
endinterface

interface rmt_out_if
    import rmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CNT_W       = $clog2(CAPACITY_DEF + 1)
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] median_value;
    logic [CNT_W-1:0]       held_count;
    logic [SUM_W-1:0]       median_sum;
    logic                   store_full;

    modport source (output valid, output median_value, output held_count,
                    output median_sum, output store_full, input ready);
    modport sink   (input valid, input median_value, input held_count,
                    input median_sum, input store_full, output ready);
endinterface

>>> rtl/rmt_cell.sv
// One cell of the sorted chain: holds one sample and takes a neighbor's value or the key.
// Depends on rmt_pkg for the control struct.
module rmt_cell
    import rmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX_W       = $clog2(CAPACITY_DEF + 1),
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [IDX_W-1:0]       i_lo,
    input  logic [IDX_W-1:0]       i_hi,
    input  logic [VALUE_WIDTH-1:0] i_left_val,
    input  logic                   i_left_gt,
    input  logic [VALUE_WIDTH-1:0] i_right_val,
    input  logic                   i_right_gt,
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic                   o_gt
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   w_below;
    logic                   w_above;

    // Cells outside the occupied span act as minus infinity below it and
    // plus infinity above it, so the unwritten contents never matter.
    assign w_below = (MY_IDX < i_lo);
    assign w_above = (MY_IDX > i_hi);
    assign o_gt    = w_above | (!w_below & ($signed(r_val) > $signed(i_key)));
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.en) begin
            if (i_ctl.shift_left) begin
                if (!i_right_gt) begin
                    n_val = i_right_val;
                end else if (!o_gt) begin
                    n_val = i_key;
                end
            end else begin
                if (i_left_gt) begin
                    n_val = i_left_val;
                end else if (o_gt) begin
                    n_val = i_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> rtl/running_median_tracker.sv
// Top level of the running median tracker: insertion chain, span counters, result stage.
// Depends on rmt_pkg, rmt_if, rmt_cell and running_median_tracker_macros.svh.
//
// Usage: every request on i_in carries one signed sample. Each one produces
// exactly one result on o_out: the lower median (rank ceil(count/2)) of all
// samples held, the held count, a 64-bit wrapping sum of every median given
// so far, and a flag that is set when the sample was dropped because the
// store already held CAPACITY samples.
// The store is a row of CAPACITY cells kept in ascending order. The median
// always lives in the middle cell: an insertion moves the larger samples one
// cell up, or, when the median rank grows, moves the smaller ones one cell
// down. Every cell decides from its two neighbors alone.
// Throughput is one request per cycle while the receiver keeps up. The accepting
// edge updates the cell row and fills the update stage; the result register then
// loads the middle cell, adds it to the sum and raises o_out.valid, unless the
// receiver still holds an earlier result.
// Reset clears the count and the sum and sets an empty span around the middle
// cell; no clearing pass is needed. i_in.ready is held low during reset and
// rises in the first cycle after it.
// When the receiver stalls, the result register holds, one more request can
// be taken into the update stage, and then i_in.ready drops until o_out moves.
`include "running_median_tracker_macros.svh"

module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmt_in_if.sink     i_in,
    rmt_out_if.source  o_out
);

    // Cell that always holds the lower median once anything is stored.
    localparam int MID = (CAPACITY + 1) / 2 - 1;
    localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LO_RESET = CNT_W'(MID + 1);
    localparam logic [CNT_W-1:0] HI_RESET = CNT_W'(MID);

    // Occupied span [r_lo, r_hi] of the cell row and the number of samples held.
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] n_lo;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] n_hi;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Update stage: a request whose insertion has just been applied.
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             r_s1_full;
    logic [CNT_W-1:0] r_s1_count;

    // Result register and median accumulator.
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [VALUE_WIDTH-1:0] r_med;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_full;
    logic [SUM_W-1:0]       r_sum;

    logic                   w_in_acc;
    logic                   w_can_load;
    logic                   w_load;
    logic                   w_full_now;
    logic signed [VALUE_WIDTH-1:0] w_mid_val;
    logic signed [SUM_W-1:0]       w_mid_ext;
    t_cell_ctl              w_ctl;

    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]    w_gt;

    // No request is taken while reset is held.
    assign w_can_load = !r_out_valid || o_out.ready;
    assign w_load     = r_s1_valid && w_can_load;
    assign i_in.ready = i_rst_n && (!r_s1_valid || w_can_load);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_full_now = (r_count == CAP_C);

    // An even count before the insertion means the median rank moves up by one.
    assign w_ctl.en         = w_in_acc && !w_full_now;
    assign w_ctl.shift_left = !r_count[0];

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_count = r_count;
        if (w_ctl.en) begin
            n_count = r_count + CNT_W'(1);
            if (w_ctl.shift_left) begin
                n_lo = r_lo - CNT_W'(1);
            end else begin
                n_hi = r_hi + CNT_W'(1);
            end
        end
        n_s1_valid  = w_in_acc || (r_s1_valid && !w_can_load);
        n_out_valid = w_load || (r_out_valid && !o_out.ready);
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_lv;
            logic                   w_lg;
            logic [VALUE_WIDTH-1:0] w_rv;
            logic                   w_rg;
            if (i == 0) begin : g_first
                assign w_lv = i_in.new_value;
                assign w_lg = 1'b0;
            end else begin : g_inner_l
                assign w_lv = w_val[i-1];
                assign w_lg = w_gt[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_rv = i_in.new_value;
                assign w_rg = 1'b1;
            end else begin : g_inner_r
                assign w_rv = w_val[i+1];
                assign w_rg = w_gt[i+1];
            end
            rmt_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX_W       (CNT_W),
                .INDEX       (i)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_key       (i_in.new_value),
                .i_lo        (r_lo),
                .i_hi        (r_hi),
                .i_left_val  (w_lv),
                .i_left_gt   (w_lg),
                .i_right_val (w_rv),
                .i_right_gt  (w_rg),
                .o_val       (w_val[i]),
                .o_gt        (w_gt[i])
            );
        end
    endgenerate

    // The middle cell is stable while the update stage waits, because no new
    // request is taken until the result register can load.
    assign w_mid_val = $signed(w_val[MID]);
    assign w_mid_ext = SUM_W'(w_mid_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= LO_RESET;
            r_hi        <= HI_RESET;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_count     <= n_count;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_load) begin
                r_sum <= r_sum + w_mid_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_full  <= w_full_now;
            r_s1_count <= n_count;
        end
        if (w_load) begin
            r_med       <= w_val[MID];
            r_out_count <= r_s1_count;
            r_out_full  <= r_s1_full;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.median_value = r_med;
    assign o_out.held_count   = r_out_count;
    assign o_out.median_sum   = r_sum;
    assign o_out.store_full   = r_out_full;

    // The occupied span always covers exactly the held samples.
    `RMT_ASSERT(a_span_matches_count,
        ({1'b0, r_hi} + (CNT_W+1)'(1)) == ({1'b0, r_lo} + {1'b0, r_count}),
        "cell span does not match count")
    `RMT_ASSERT(a_count_bound, r_count <= CAP_C, "count exceeds capacity")
    `RMT_ASSERT(a_accept_reaches_stage, w_in_acc |=> r_s1_valid,
        "accepted request lost before result stage")
    `RMT_ASSERT(a_sum_holds_on_stall, (r_out_valid && !o_out.ready) |=> $stable(r_sum),
        "median sum moved while result stalled")
    `RMT_ASSERT(a_full_means_capacity, (r_out_valid && r_out_full) |-> (r_out_count == CAP_C),
        "drop flagged below capacity")

endmodule

>>> tb/running_median_tracker_tb.sv
// Self-checking testbench for running_median_tracker: sorted-store lower median,
// count, running median sum and store-full flag, checked on every result.
// Depends on rmt_pkg, the rmt_in_if/rmt_out_if interfaces and the tracker RTL.
module running_median_tracker_tb
    import rmt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP   = CAPACITY_DEF;
    localparam int VW    = VALUE_WIDTH_DEF;
    localparam int CNT_W = $clog2(CAP + 1);

    // Receiver hold-off used to fill the block and force i_in.ready low.
    localparam int unsigned RX_LONG_HOLD = 60;
    // Generous run limit in ns; the slowest legal run is well under a tenth of it.
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    localparam logic [VW-1:0] SAMPLE_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] SAMPLE_MAX = {1'b0, {(VW-1){1'b1}}};

    // One expected result of the tracker.
    typedef struct {
        logic [VW-1:0]    median_value;
        logic [CNT_W-1:0] held_count;
        logic [SUM_W-1:0] median_sum;
        logic             store_full;
    } t_median_result;

    // How the receiver drives o_out.ready while no long hold-off is running.
    typedef enum int unsigned {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_pattern;

    // Flavors of random sample, chosen to hit the ends of the sorted store,
    // the neighborhood of the median, duplicates and monotone runs.
    typedef enum int unsigned {
        PICK_ANY,
        PICK_EXTREME,
        PICK_NEAR_MEDIAN,
        PICK_SMALL,
        PICK_REPEAT,
        PICK_RISING,
        PICK_FALLING
    } t_sample_pick;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmt_in_if  #(.VALUE_WIDTH(VW))                  sample_ch ();
    rmt_out_if #(.VALUE_WIDTH(VW), .CNT_W(CNT_W))   median_ch ();

    running_median_tracker #(
        .CAPACITY    (CAP),
        .VALUE_WIDTH (VW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (median_ch)
    );

    // 4 ns period clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own sorted copy of every stored sample, the
    // wrapping 64-bit sum of medians, and the queue of results still owed.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] sorted_samples [$];
    logic [SUM_W-1:0]     median_total;
    logic [VW-1:0]        latest_sample;
    logic [VW-1:0]        latest_median;
    t_median_result       pending_medians [$];
    int unsigned          samples_accepted;
    int unsigned          mismatch_count = 0;

    // Receiver control; a test bumps rx_holds_asked to request a long hold.
    int unsigned rx_holds_asked;
    int unsigned rx_holds_done = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_phase      = 0;
    t_rx_pattern rx_mode       = RX_ALWAYS;

    // Inserts one sample after any equal ones (unless the store is full) and
    // returns the lower median of rank ceil(count/2), the count, the running
    // sum and the full flag.
    function automatic t_median_result insert_and_take_median(input logic [VW-1:0] sample);
        t_median_result r;
        int             pos;
        r.store_full = (sorted_samples.size() >= CAP);
        if (!r.store_full) begin
            pos = sorted_samples.size();
            while (pos > 0 && sorted_samples[pos-1] > $signed(sample))
                pos--;
            sorted_samples.insert(pos, sample);
        end
        r.median_value = sorted_samples[(sorted_samples.size() + 1) / 2 - 1];
        r.held_count   = CNT_W'(sorted_samples.size());
        median_total   = median_total
                       + {{(SUM_W-VW){r.median_value[VW-1]}}, r.median_value};
        r.median_sum   = median_total;
        latest_sample  = sample;
        latest_median  = r.median_value;
        return r;
    endfunction

    // Random sample with a bias toward the interesting regions of the store.
    function automatic logic [VW-1:0] random_sample();
        t_sample_pick pick;
        if ($urandom_range(0, 3) == 0)
            pick = PICK_ANY;
        else
            pick = t_sample_pick'($urandom_range(0, PICK_FALLING));
        case (pick)
            PICK_EXTREME:
                return $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 2)
                                            : SAMPLE_MIN + $urandom_range(0, 2);
            PICK_NEAR_MEDIAN: return latest_median + $urandom_range(0, 16) - 32'd8;
            PICK_SMALL:       return $urandom_range(0, 64) - 32'd32;
            PICK_REPEAT:      return latest_sample;
            PICK_RISING:      return latest_sample + $urandom_range(0, 5000);
            PICK_FALLING:     return latest_sample - $urandom_range(0, 5000);
            default:          return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. Each call is entered just after a rising edge; valid is
    // raised (or kept high) and held until the block takes the request.
    // Inputs are sampled right after the edge, so they show pre-edge values.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [VW-1:0] sample);
        sample_ch.valid     <= 1'b1;
        sample_ch.new_value <= sample;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        pending_medians.push_back(insert_and_take_median(sample));
        samples_accepted++;
    endtask

    // Sender gap: valid low with junk on the data lines, which must be ignored.
    task automatic idle_sender(input int unsigned cycles);
        sample_ch.valid     <= 1'b0;
        sample_ch.new_value <= $urandom;
        repeat (cycles)
            @(posedge i_clk);
    endtask

    // Sender pauses until every owed result has been checked.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge i_clk);
    endtask

    // Random requests in bursts of random length; about one gap in four is
    // skipped so that long back-to-back stretches also occur.
    task automatic send_random_stream(input int unsigned n_items);
        int unsigned left;
        int unsigned burst;
        left = n_items;
        while (left != 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                send_sample(random_sample());
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Extremes of the sample range, sign-bit patterns, duplicates and the
    // single-sample store, sent back to back.
    task automatic test_directed_corners();
        send_sample('0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('1);
        send_sample(VW'(1));
        repeat (4)
            send_sample(VW'(7));
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);
        send_sample(SAMPLE_MAX - 1'b1);
        send_sample(SAMPLE_MIN + 1'b1);
        send_sample('1);
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering requests, so the result and update stages fill and the block
    // must stall its input without losing or duplicating anything.
    task automatic test_receiver_hold();
        rx_holds_asked++;
        repeat (24)
            send_sample(random_sample());
        wait_for_drain();
    endtask

    // Random traffic until the store is a few samples short of full.
    task automatic test_random_fill();
        if (samples_accepted < CAP - 8)
            send_random_stream(CAP - 8 - samples_accepted);
        wait_for_drain();
    endtask

    // Crosses into the full state: the last free entries are taken, then
    // extremes and mid values are dropped while the median keeps counting.
    task automatic test_store_full();
        while (sorted_samples.size() < CAP)
            send_sample(random_sample());
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(latest_median);
        repeat (12)
            send_sample(random_sample());
        wait_for_drain();
    endtask

    // Random traffic with the store full, with a second long receiver hold.
    task automatic test_random_when_full();
        send_random_stream(400);
        wait_for_drain();
        test_receiver_hold();
        send_random_stream(420);
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: o_out.ready follows a pattern that is picked anew at random intervals,
    // overridden by a counted long hold-off when a test asks for one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_holds_done != rx_holds_asked) begin
            rx_holds_done = rx_holds_asked;
            rx_hold_left  = RX_LONG_HOLD;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_pattern'($urandom_range(0, RX_SPARSE));
            rx_mode_left = $urandom_range(8, 80);
        end
        rx_mode_left--;
        rx_phase++;
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            median_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   median_ch.ready <= 1'b1;
                RX_COIN:     median_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: median_ch.ready <= (rx_phase % 3) != 0;
                default:     median_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result is matched against the oldest
    // owed result, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_median_result want;
        if (i_rst_n && median_ch.valid && median_ch.ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: result with no request outstanding: median %0d count %0d",
                         $realtime, $signed(median_ch.median_value), median_ch.held_count);
                mismatch_count++;
            end else begin
                want = pending_medians.pop_front();
                if (median_ch.median_value !== want.median_value) begin
                    $display("%0t: median_value expected %0d actual %0d", $realtime,
                             $signed(want.median_value), $signed(median_ch.median_value));
                    mismatch_count++;
                end
                if (median_ch.held_count !== want.held_count) begin
                    $display("%0t: held_count expected %0d actual %0d", $realtime,
                             want.held_count, median_ch.held_count);
                    mismatch_count++;
                end
                if (median_ch.median_sum !== want.median_sum) begin
                    $display("%0t: median_sum expected %0d actual %0d", $realtime,
                             $signed(want.median_sum), $signed(median_ch.median_sum));
                    mismatch_count++;
                end
                if (median_ch.store_full !== want.store_full) begin
                    $display("%0t: store_full expected %0b actual %0b", $realtime,
                             want.store_full, median_ch.store_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit: a hang anywhere ends here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence: reset once, then the tests in turn.
    initial begin
        median_total     = '0;
        latest_sample    = '0;
        latest_median    = '0;
        samples_accepted = 0;
        rx_holds_asked   = 0;

        i_rst_n             <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.new_value <= '0;
        repeat (4)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_receiver_hold();
        test_random_fill();
        test_store_full();
        test_random_when_full();

        // Everything is drained; give the two-stage pipe time to show any
        // stray result before deciding.
        wait_for_drain();
        repeat (8)
            @(posedge i_clk);
        if (mismatch_count == 0 && pending_medians.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
